[rtl/core/stlq_pkg.sv]
// package for the session table with lru eviction and per-source quota
// holds slot and control types, status and register codes; no dependencies
`default_nettype none
package stlq_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int KEY_W         = 34;

    localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REAP_MIN_AGE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_CAP   = 2'd2;

    localparam logic [2:0] STAT_REFRESHED = 3'd0;
    localparam logic [2:0] STAT_FREE      = 3'd1;
    localparam logic [2:0] STAT_OWN_EVICT = 3'd2;
    localparam logic [2:0] STAT_REAPED    = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;
    localparam logic [2:0] STAT_FOUND     = 3'd5;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd6;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_FIND     = 1'b1;

    typedef struct packed {
        logic             live;
        logic [63:0]      id_hi;
        logic [63:0]      id_lo;
        logic [31:0]      seen;
        logic [KEY_W-1:0] source;
    } t_slot;

    typedef struct packed {
        logic full;
        logic seen_only;
    } t_cell_wr;

    typedef struct packed {
        logic hit;
        logic have_free;
        logic have_lru;
        logic have_src;
    } t_scan_flags;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEC,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

[rtl/core/stlq_in_if.sv]
// request channel of the session table: valid, ready and request fields
// standalone interface, no dependencies
`default_nettype none
interface stlq_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] session_id_hi;
    logic [63:0] session_id_lo;
    logic [1:0]  source_kind;
    logic [31:0] source_hash;
    logic [31:0] current_time;

    modport source (output valid, op, session_id_hi, session_id_lo, source_kind,
                    source_hash, current_time, input ready);
    modport sink (input valid, op, session_id_hi, session_id_lo, source_kind,
                  source_hash, current_time, output ready);
endinterface
`default_nettype wire

[rtl/core/stlq_out_if.sv]
// result channel of the session table: valid, ready and result fields
// standalone interface, no dependencies
`default_nettype none
interface stlq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic        victim_valid;
    logic [63:0] victim_id_hi;
    logic [63:0] victim_id_lo;

    modport source (output valid, status, slot_index, victim_valid, victim_id_hi,
                    victim_id_lo, input ready);
    modport sink (input valid, status, slot_index, victim_valid, victim_id_hi,
                  victim_id_lo, output ready);
endinterface
`default_nettype wire

[rtl/core/session_table_lru_quota.sv]
// session table with lru eviction and per-source quota, top level
// Requests enter on i_in (valid/ready): register (refresh or insert) or find.
// Results leave on o_out (valid/ready), one result per request.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 slots in use, 1 reap minimum age, 2 source cap). The user writes only
// while idle; the block itself does not enforce this.
// The slots sit in a row of cells. A request rotates the row once past the
// scan unit at its head, which collects the matching slot, the first free
// slot, the oldest slot and the own oldest. The decision state then
// decides, writes the chosen cell of a register request and loads the result.
// A new request is taken only once the previous result has been taken.
// Reset: synchronous, active low; all slots become free and the registers
// return to 64 slots, 30000 ms reap age and a source cap of 64.
// A stalled receiver holds the result steady and keeps i_in.ready low.
// depends on stlq_pkg, stlq_in_if, stlq_out_if, stlq_cell, stlq_scan
`default_nettype none
module session_table_lru_quota
    import stlq_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    stlq_in_if.sink                     i_in,
    stlq_out_if.source                  o_out,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    t_state r_state, n_state;

    logic [6:0]  r_slots_in_use;
    logic [31:0] r_reap_min_age;
    logic [6:0]  r_source_cap;

    logic             r_op;
    logic [63:0]      r_id_hi, r_id_lo;
    logic [KEY_W-1:0] r_key;
    logic [31:0]      r_now;
    logic             keyed;

    logic [IW-1:0] r_k;

    logic [2:0]  r_status;
    logic [5:0]  r_slot_index;
    logic        r_victim_valid;
    logic [63:0] r_victim_id_hi, r_victim_id_lo;

    logic          accept, shift, step;
    t_slot         cells [MAX_SLOTS];
    t_slot         wr_data;
    t_scan_flags   flags;
    logic [IW-1:0] hit_idx, free_idx, lru_idx, src_idx;
    logic [31:0]   oldest_time, age;
    logic [127:0]  lru_id, src_id;
    logic [CW-1:0] own_count;

    logic          do_insert, do_refresh, victim;
    logic [IW-1:0] target;
    logic [2:0]    status;
    logic [127:0]  victim_id;

    assign accept = i_in.valid && i_in.ready;
    assign shift  = (r_state == ST_SCAN);
    assign step   = shift && (32'(r_k) < 32'(r_slots_in_use));
    assign keyed  = (r_key[KEY_W-1:KEY_W-2] != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= 7'd64;
            r_reap_min_age <= 32'd30000;
            r_source_cap   <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLOTS_IN_USE: r_slots_in_use <= i_cfg_data[6:0];
                CFG_REAP_MIN_AGE: r_reap_min_age <= i_cfg_data;
                CFG_SOURCE_CAP:   r_source_cap   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_in.op;
            r_id_hi <= i_in.session_id_hi;
            r_id_lo <= i_in.session_id_lo;
            r_key   <= {i_in.source_kind, i_in.source_hash};
            r_now   <= i_in.current_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || accept) begin
            r_k <= '0;
        end else if (shift) begin
            r_k <= r_k + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_SCAN;
            ST_SCAN: if (r_k == IW'(MAX_SLOTS - 1)) n_state = ST_DEC;
            ST_DEC:  n_state = ST_OUT;
            ST_OUT:  if (o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // cell row, rotating toward cell 0
    assign wr_data = '{live: 1'b1, id_hi: r_id_hi, id_lo: r_id_lo, seen: r_now,
                       source: r_key};

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        t_cell_wr wr;
        assign wr.full      = do_insert && (target == IW'(g));
        assign wr.seen_only = do_refresh && (hit_idx == IW'(g));
        stlq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (shift),
            .i_nbr     (cells[(g + 1) % MAX_SLOTS]),
            .i_wr      (wr),
            .i_wr_data (wr_data),
            .o_slot    (cells[g])
        );
    end

    stlq_scan #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_step        (step),
        .i_idx         (r_k),
        .i_slot        (cells[0]),
        .i_id_hi       (r_id_hi),
        .i_id_lo       (r_id_lo),
        .i_key         (r_key),
        .i_keyed       (keyed),
        .o_flags       (flags),
        .o_hit_idx     (hit_idx),
        .o_free_idx    (free_idx),
        .o_lru_idx     (lru_idx),
        .o_oldest_time (oldest_time),
        .o_lru_id      (lru_id),
        .o_src_idx     (src_idx),
        .o_src_id      (src_id),
        .o_own_count   (own_count)
    );

    assign age = r_now - oldest_time;

    always_comb begin
        status     = STAT_FULL;
        target     = '0;
        victim     = 1'b0;
        victim_id  = '0;
        do_insert  = 1'b0;
        do_refresh = 1'b0;
        if (r_state == ST_DEC) begin
            if (r_op == OP_FIND) begin
                status = flags.hit ? STAT_FOUND : STAT_NOT_FOUND;
                target = flags.hit ? hit_idx : '0;
            end else begin
                priority if (flags.hit) begin
                    status     = STAT_REFRESHED;
                    target     = hit_idx;
                    do_refresh = 1'b1;
                end else if (keyed && flags.have_src &&
                             32'(own_count) >= 32'(r_source_cap)) begin
                    status    = STAT_OWN_EVICT;
                    target    = src_idx;
                    victim    = 1'b1;
                    victim_id = src_id;
                    do_insert = 1'b1;
                end else if (flags.have_free) begin
                    status    = STAT_FREE;
                    target    = free_idx;
                    do_insert = 1'b1;
                end else if (flags.have_lru && age >= r_reap_min_age) begin
                    status    = STAT_REAPED;
                    target    = lru_idx;
                    victim    = 1'b1;
                    victim_id = lru_id;
                    do_insert = 1'b1;
                end else begin
                    status = STAT_FULL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DEC) begin
            r_status       <= status;
            r_slot_index   <= 6'(target);
            r_victim_valid <= victim;
            r_victim_id_hi <= victim_id[127:64];
            r_victim_id_lo <= victim_id[63:0];
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = (r_state == ST_OUT);
    assign o_out.status        = r_status;
    assign o_out.slot_index    = r_slot_index;
    assign o_out.victim_valid  = r_victim_valid;
    assign o_out.victim_id_hi  = r_victim_id_hi;
    assign o_out.victim_id_lo  = r_victim_id_lo;

endmodule
`default_nettype wire

[rtl/core/stlq_cell.sv]
// one table slot; rotates its contents to the neighbor during a scan
// depends on stlq_pkg
`default_nettype none
module stlq_cell
    import stlq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_shift,
    input  wire t_slot    i_nbr,
    input  wire t_cell_wr i_wr,
    input  wire t_slot    i_wr_data,
    output t_slot         o_slot
);

    logic  r_live;
    t_slot r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_shift) begin
            r_live <= i_nbr.live;
        end else if (i_wr.full) begin
            r_live <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_nbr;
        end else if (i_wr.full) begin
            r_data <= i_wr_data;
        end else if (i_wr.seen_only) begin
            r_data.seen <= i_wr_data.seen;
        end
    end

    always_comb begin
        o_slot      = r_data;
        o_slot.live = r_live;
    end

endmodule
`default_nettype wire

[rtl/core/stlq_scan.sv]
// scan unit at the head of the cell row: match, first free, oldest, own oldest
// depends on stlq_pkg
`default_nettype none
module stlq_scan
    import stlq_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_step,
    input  wire logic [$clog2(MAX_SLOTS)-1:0]   i_idx,
    input  wire t_slot                          i_slot,
    input  wire logic [63:0]                    i_id_hi,
    input  wire logic [63:0]                    i_id_lo,
    input  wire logic [KEY_W-1:0]               i_key,
    input  wire logic                           i_keyed,
    output t_scan_flags                         o_flags,
    output logic [$clog2(MAX_SLOTS)-1:0]        o_hit_idx,
    output logic [$clog2(MAX_SLOTS)-1:0]        o_free_idx,
    output logic [$clog2(MAX_SLOTS)-1:0]        o_lru_idx,
    output logic [31:0]                         o_oldest_time,
    output logic [127:0]                        o_lru_id,
    output logic [$clog2(MAX_SLOTS)-1:0]        o_src_idx,
    output logic [127:0]                        o_src_id,
    output logic [$clog2(MAX_SLOTS+1)-1:0]      o_own_count
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    t_scan_flags     r_flags;
    logic [IW-1:0]   r_hit_idx, r_free_idx, r_lru_idx, r_src_idx;
    logic [31:0]     r_oldest_time, r_src_seen;
    logic [127:0]    r_lru_id, r_src_id;
    logic [CW-1:0]   r_own_count;
    logic            id_match, src_match, take;

    assign take      = i_step && !r_flags.hit;
    assign id_match  = (i_slot.id_hi == i_id_hi) && (i_slot.id_lo == i_id_lo);
    assign src_match = i_keyed && (i_slot.source == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags     <= '0;
            r_own_count <= '0;
        end else if (take && i_slot.live) begin
            if (id_match) begin
                r_flags.hit <= 1'b1;
            end else begin
                if (!r_flags.have_lru || i_slot.seen < r_oldest_time) begin
                    r_flags.have_lru <= 1'b1;
                end
                if (src_match) begin
                    r_own_count <= r_own_count + CW'(1);
                    r_flags.have_src <= 1'b1;
                end
            end
        end else if (take && !r_flags.have_free) begin
            r_flags.have_free <= 1'b1;
        end
    end

    // payload side, qualified by the same conditions as the flags
    always_ff @(posedge i_clk) begin
        if (take && i_slot.live) begin
            if (id_match) begin
                r_hit_idx <= i_idx;
            end else begin
                if (!r_flags.have_lru || i_slot.seen < r_oldest_time) begin
                    r_lru_idx     <= i_idx;
                    r_oldest_time <= i_slot.seen;
                    r_lru_id      <= {i_slot.id_hi, i_slot.id_lo};
                end
                if (src_match && (!r_flags.have_src || i_slot.seen < r_src_seen)) begin
                    r_src_idx  <= i_idx;
                    r_src_seen <= i_slot.seen;
                    r_src_id   <= {i_slot.id_hi, i_slot.id_lo};
                end
            end
        end else if (take && !r_flags.have_free) begin
            r_free_idx <= i_idx;
        end
    end

    assign o_flags       = r_flags;
    assign o_hit_idx     = r_hit_idx;
    assign o_free_idx    = r_free_idx;
    assign o_lru_idx     = r_lru_idx;
    assign o_oldest_time = r_oldest_time;
    assign o_lru_id      = r_lru_id;
    assign o_src_idx     = r_src_idx;
    assign o_src_id      = r_src_id;
    assign o_own_count   = r_own_count;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// testbench for the session table with lru eviction and per-source quota
// drives requests and configuration writes, predicts every result and compares them
// depends on stlq_pkg, stlq_in_if, stlq_out_if and session_table_lru_quota
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import stlq_pkg::*;

    typedef struct packed {
        logic        op;
        logic [63:0] id_hi;
        logic [63:0] id_lo;
        logic [1:0]  kind;
        logic [31:0] hash;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic        victim;
        logic [63:0] vhi;
        logic [63:0] vlo;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    stlq_in_if in_ch ();
    stlq_out_if out_ch ();

    session_table_lru_quota DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic        tbl_live [64];
    logic [63:0] tbl_hi   [64];
    logic [63:0] tbl_lo   [64];
    logic [31:0] tbl_seen [64];
    logic [33:0] tbl_src  [64];
    int unsigned cfg_slots = 64;
    logic [31:0] cfg_age = 30000;
    int unsigned cfg_cap = 64;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   mismatches = 0;
    int   hold_cycles = 0;
    bit   gaps_on = 1'b1;
    bit   in_acc = 1'b0;

    function automatic t_res predict_session(t_req r);
        t_res o;
        int unsigned n;
        logic [33:0] key;
        bit have_free, have_lru, have_src, keyed;
        int free_i, lru_i, src_i, cnt, tgt;
        logic [31:0] lru_t, src_t;
        o = '0;
        n = (cfg_slots > 64) ? 64 : cfg_slots;
        key = {r.kind, r.hash};
        keyed = (r.kind != 2'd0);
        have_free = 0; have_lru = 0; have_src = 0;
        free_i = 0; lru_i = 0; src_i = 0; cnt = 0; lru_t = 0; src_t = 0;
        if (r.op == OP_FIND) begin
            o.status = STAT_NOT_FOUND;
            for (int i = 0; i < n; i++) begin
                if (tbl_live[i] && tbl_hi[i] == r.id_hi && tbl_lo[i] == r.id_lo) begin
                    o.status = STAT_FOUND;
                    o.slot = i[5:0];
                    return o;
                end
            end
            return o;
        end
        for (int i = 0; i < n; i++) begin
            if (!tbl_live[i]) begin
                if (!have_free) begin
                    have_free = 1; free_i = i;
                end
                continue;
            end
            if (tbl_hi[i] == r.id_hi && tbl_lo[i] == r.id_lo) begin
                tbl_seen[i] = r.now;
                o.status = STAT_REFRESHED;
                o.slot = i[5:0];
                return o;
            end
            if (!have_lru || tbl_seen[i] < lru_t) begin
                have_lru = 1; lru_i = i; lru_t = tbl_seen[i];
            end
            if (keyed && tbl_src[i] == key) begin
                cnt++;
                if (!have_src || tbl_seen[i] < src_t) begin
                    have_src = 1; src_i = i; src_t = tbl_seen[i];
                end
            end
        end
        if (keyed && cnt >= cfg_cap && have_src) begin
            tgt = src_i; o.status = STAT_OWN_EVICT; o.victim = 1;
        end else if (have_free) begin
            tgt = free_i; o.status = STAT_FREE;
        end else if (have_lru && (r.now - lru_t) >= cfg_age) begin
            tgt = lru_i; o.status = STAT_REAPED; o.victim = 1;
        end else begin
            o.status = STAT_FULL;
            return o;
        end
        if (o.victim) begin
            o.vhi = tbl_hi[tgt]; o.vlo = tbl_lo[tgt];
        end
        tbl_hi[tgt] = r.id_hi; tbl_lo[tgt] = r.id_lo; tbl_seen[tgt] = r.now;
        tbl_src[tgt] = key; tbl_live[tgt] = 1;
        o.slot = tgt[5:0];
        return o;
    endfunction

    function automatic int gap_len();
        if (!gaps_on || $urandom_range(0, 3) != 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
    endfunction

    // driver; a request stays on the channel until it has been taken
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_acc) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            t_req r;
            r = pending_reqs.pop_front();
            in_ch.valid <= 1'b1;
            {in_ch.op, in_ch.session_id_hi, in_ch.session_id_lo, in_ch.source_kind,
             in_ch.source_hash, in_ch.current_time} <= r;
            send_gap <= gap_len();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            expected_results.push_back(predict_session({in_ch.op, in_ch.session_id_hi,
                in_ch.session_id_lo, in_ch.source_kind, in_ch.source_hash,
                in_ch.current_time}));
    end

    // receiver stall
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            recv_gap <= gap_len();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_res got, exp_r;
            got = {out_ch.status, out_ch.slot_index, out_ch.victim_valid,
                   out_ch.victim_id_hi, out_ch.victim_id_lo};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, got);
                end
            end
        end
    end

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SLOTS_IN_USE: cfg_slots = val[6:0];
            CFG_REAP_MIN_AGE: cfg_age = val;
            CFG_SOURCE_CAP:   cfg_cap = val[6:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // ids from a small pool so refreshes and finds hit; time mostly advances
    logic [31:0] clock_ms = 0;
    function automatic t_req random_session(int pool);
        t_req r;
        int k;
        k = $urandom_range(0, pool - 1);
        r.op = ($urandom_range(0, 3) == 0) ? OP_FIND : OP_REGISTER;
        if ($urandom_range(0, 15) == 0) begin
            r.id_hi = {$urandom, $urandom}; r.id_lo = {$urandom, $urandom};
        end else begin
            r.id_hi = {32'hA5A5_0000, k}; r.id_lo = {~k, $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF};
        end
        r.kind = 2'($urandom_range(0, 3));
        r.hash = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2);
        clock_ms = clock_ms + $urandom_range(0, 20000);
        r.now = ($urandom_range(0, 31) == 0) ? $urandom : clock_ms;
        return r;
    endfunction

    function automatic t_req make_req(logic op, logic [63:0] hi, logic [63:0] lo,
                                      logic [1:0] kind, logic [31:0] hash, logic [31:0] now);
        return {op, hi, lo, kind, hash, now};
    endfunction

    initial begin
        for (int i = 0; i < 64; i++) begin
            tbl_live[i] = 0; tbl_hi[i] = 0; tbl_lo[i] = 0; tbl_seen[i] = 0; tbl_src[i] = 0;
        end
        in_ch.valid = 0; in_ch.op = 0; in_ch.session_id_hi = 0; in_ch.session_id_lo = 0;
        in_ch.source_kind = 0; in_ch.source_hash = 0; in_ch.current_time = 0;
        out_ch.ready = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small table, extremes, own eviction, reap, full, find
        cfg_write(CFG_SLOTS_IN_USE, 4);
        cfg_write(CFG_REAP_MIN_AGE, 100);
        cfg_write(CFG_SOURCE_CAP, 2);
        pending_reqs.push_back(make_req(OP_FIND, '1, '1, 3, '1, '1));
        pending_reqs.push_back(make_req(OP_REGISTER, '1, '1, 1, 7, 10));
        pending_reqs.push_back(make_req(OP_REGISTER, 0, 0, 1, 7, 10));
        pending_reqs.push_back(make_req(OP_REGISTER, 5, 5, 1, 7, 20));
        pending_reqs.push_back(make_req(OP_REGISTER, '1, '1, 2, 9, 30));
        pending_reqs.push_back(make_req(OP_REGISTER, 6, 6, 0, '1, 40));
        pending_reqs.push_back(make_req(OP_REGISTER, 7, 7, 3, 7, 45));
        pending_reqs.push_back(make_req(OP_REGISTER, 8, 8, 0, 0, 50));
        pending_reqs.push_back(make_req(OP_REGISTER, 9, 9, 0, 0, 60));
        pending_reqs.push_back(make_req(OP_REGISTER, 10, 10, 2, 3, '1));
        pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_FIND, 6, 6, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_REGISTER, 11, 11, 0, 0, 5));
        pending_reqs.push_back(make_req(OP_FIND, 12, 12, 0, 0, 0));
        drain();
        cfg_write(CFG_SLOTS_IN_USE, 0);
        cfg_write(CFG_SOURCE_CAP, 0);
        pending_reqs.push_back(make_req(OP_REGISTER, 1, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(OP_FIND, '1, '1, 1, 1, 1));
        drain();
        cfg_write(CFG_SLOTS_IN_USE, 127);
        cfg_write(CFG_REAP_MIN_AGE, 0);
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(make_req(OP_REGISTER, 100 + i, i, 2, 4, 1000 - i));
        drain();

        // random phases, ~1600 requests across settings
        for (int ph = 0; ph < 8; ph++) begin
            int pool;
            case (ph)
                0: begin cfg_write(CFG_SLOTS_IN_USE, 64); cfg_write(CFG_REAP_MIN_AGE, 30000);
                         cfg_write(CFG_SOURCE_CAP, 64); end
                1: begin cfg_write(CFG_SLOTS_IN_USE, 8); cfg_write(CFG_SOURCE_CAP, 3); end
                2: begin cfg_write(CFG_SLOTS_IN_USE, 1); cfg_write(CFG_REAP_MIN_AGE, 0); end
                3: begin cfg_write(CFG_SLOTS_IN_USE, 16); cfg_write(CFG_REAP_MIN_AGE, '1);
                         cfg_write(CFG_SOURCE_CAP, 1); end
                4: begin cfg_write(CFG_SLOTS_IN_USE, 100); cfg_write(CFG_REAP_MIN_AGE, 50000);
                         cfg_write(CFG_SOURCE_CAP, 0); end
                5: begin cfg_write(CFG_SLOTS_IN_USE, 12); cfg_write(CFG_SOURCE_CAP, 127); end
                6: begin cfg_write(CFG_SLOTS_IN_USE, 64); cfg_write(CFG_SOURCE_CAP, 5);
                         cfg_write(CFG_REAP_MIN_AGE, $urandom_range(0, 40000)); end
                default: begin cfg_write(CFG_SLOTS_IN_USE, 32); gaps_on = 0; end
            endcase
            pool = (ph == 0 || ph == 6) ? 96 : 24;
            for (int i = 0; i < 200; i++) pending_reqs.push_back(random_session(pool));
            if (ph == 1) begin
                // hold the result side while requests keep coming
                repeat (20) @(posedge i_clk);
                @(negedge i_clk);
                hold_cycles <= 600;
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[session_table_lru_quota.f]
rtl/core/stlq_pkg.sv
rtl/core/stlq_in_if.sv
rtl/core/stlq_out_if.sv
rtl/core/stlq_cell.sv
rtl/core/stlq_scan.sv
rtl/core/session_table_lru_quota.sv
tb/tb_top.sv
